/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/dtpc_pkg.sv */
// types and constants shared by the depth to point cloud block
`timescale 1ns / 1ps
package dtpc_pkg;

  localparam int unsigned CNT_W      = 12;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned Z_W        = 24;
  localparam int unsigned COORD_W    = 25;
  localparam int unsigned IDX_W      = 24;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [COORD_W-1:0] POS_MAX = 25'h0FF_FFFF;
  localparam logic [COORD_W-1:0] NEG_MAG = 25'h100_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_SCALE  = 4'd0,
    REG_MAX_DEPTH    = 4'd1,
    REG_CENTER_X     = 4'd2,
    REG_CENTER_Y     = 4'd3,
    REG_INV_FOCAL_X  = 4'd4,
    REG_INV_FOCAL_Y  = 4'd5,
    REG_FRAME_WIDTH  = 4'd6,
    REG_FRAME_HEIGHT = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [23:0]       depth_scale;
    logic [23:0]       max_depth;
    logic [15:0]       center_x;
    logic [15:0]       center_y;
    logic [23:0]       inv_focal_x;
    logic [23:0]       inv_focal_y;
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    depth_scale:  24'd3355,
    max_depth:    24'd327680,
    center_x:     16'd5112,
    center_y:     16'd3832,
    inv_focal_x:  24'd31957,
    inv_focal_y:  24'd31957,
    frame_width:  13'd640,
    frame_height: 13'd480
  };

  typedef struct packed {
    logic [RAW_W-1:0] depth_raw;
    logic [CNT_W-1:0] column;
    logic [CNT_W-1:0] row;
    logic [IDX_W-1:0] index;
    logic             last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/dtpc_front.sv */
// request intake with column, row and raster index counters
`timescale 1ns / 1ps
module dtpc_front import dtpc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  logic [RAW_W-1:0] depth_raw_i,
  input  q_status_t        q_status_i,
  output logic             in_stall_o,
  output logic             push_o,
  output item_t            item_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] MaxW = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MaxH = SIZE_W'(MAX_HEIGHT);

  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic              row_end, frame_end;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    w_eff = (cfg_i.frame_width == '0 || cfg_i.frame_width > MaxW) ? MaxW : cfg_i.frame_width;
    h_eff = (cfg_i.frame_height == '0 || cfg_i.frame_height > MaxH) ? MaxH : cfg_i.frame_height;
    row_end   = SIZE_W'(col_q) >= (w_eff - SIZE_W'(1));
    frame_end = row_end && (SIZE_W'(row_q) >= (h_eff - SIZE_W'(1)));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    idx_d = idx_q;
    if (push_o) begin
      if (frame_end) begin
        col_d = '0;
        row_d = '0;
        idx_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + RW'(1);
        idx_d = idx_q + IDX_W'(1);
      end else begin
        col_d = col_q + CW'(1);
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      idx_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      idx_q <= idx_d;
    end
  end

  always_comb begin
    item_o.depth_raw = depth_raw_i;
    item_o.column    = CNT_W'(col_q);
    item_o.row       = CNT_W'(row_q);
    item_o.index     = idx_q;
    item_o.last      = frame_end;
  end

endmodule

/* rtl/dtpc_queue.sv */
// short request queue between intake and arithmetic pipeline
`timescale 1ns / 1ps
module dtpc_queue import dtpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     item_i,
  input  logic      pop_i,
  output item_t     item_o,
  output q_status_t status_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  item_t           mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CNTW'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign item_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? PW'((32'(wr_q) + 32'd1) % QUEUE_DEPTH) : wr_q;
    rd_d  = pop_i  ? PW'((32'(rd_q) + 32'd1) % QUEUE_DEPTH) : rd_q;
    cnt_d = cnt_q + CNTW'(push_i) - CNTW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

/* rtl/dtpc_back.sv */
// four stage back-projection pipeline with output register
`timescale 1ns / 1ps
module dtpc_back import dtpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  q_status_t          q_status_i,
  input  item_t              item_i,
  output logic               pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [COORD_W-1:0] point_x_o,
  output logic [COORD_W-1:0] point_y_o,
  output logic [Z_W-1:0]     point_z_o,
  output logic [IDX_W-1:0]   pixel_index_o,
  output logic               clipped_o,
  output logic               last_of_frame_o
);

  function automatic logic [COORD_W-1:0] lat_finish(input logic neg,
                                                    input logic [51:0] hi,
                                                    input logic [51:0] lo);
    logic [52:0]        sum;
    logic [36:0]        r;
    logic [COORD_W-1:0] rc;
    logic [COORD_W-1:0] res;
    sum = {1'b0, hi} + {13'd0, lo[51:12]};
    r   = sum[52:16];
    if (!neg) begin
      res = (r > 37'(POS_MAX)) ? POS_MAX : {1'b0, r[23:0]};
    end else begin
      rc  = (r > 37'(NEG_MAG)) ? NEG_MAG : r[COORD_W-1:0];
      res = -rc;
    end
    return res;
  endfunction

  logic en;
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;

  // stage 1: depth product and signed pixel offsets
  logic [39:0]      zprod;
  logic [16:0]      dx, dy;
  logic [31:0]      s1_z_q;
  logic             s1_xneg_q, s1_yneg_q;
  logic [15:0]      s1_xmag_q, s1_ymag_q;
  logic [IDX_W-1:0] s1_idx_q, s2_idx_q, s3_idx_q;
  logic             s1_last_q, s2_last_q, s3_last_q;

  // stage 2: clip decision and offset times depth
  logic             s2_clip_q, s3_clip_q;
  logic [Z_W-1:0]   s2_z_q, s3_z_q;
  logic             s2_xneg_q, s2_yneg_q, s3_xneg_q, s3_yneg_q;
  logic [39:0]      s2_px_q, s2_py_q;

  // stage 3: split products with reciprocals
  logic [51:0]      s3_xhi_q, s3_xlo_q, s3_yhi_q, s3_ylo_q;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !q_status_i.empty;

  always_comb begin
    zprod = 40'(item_i.depth_raw) * 40'(cfg_i.depth_scale);
    dx    = {1'b0, item_i.column, 4'd0} - {1'b0, cfg_i.center_x};
    dy    = {1'b0, item_i.row, 4'd0} - {1'b0, cfg_i.center_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= !q_status_i.empty;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_z_q    <= zprod[39:8];
      s1_xneg_q <= dx[16];
      s1_yneg_q <= dy[16];
      s1_xmag_q <= dx[16] ? 16'(-dx) : dx[15:0];
      s1_ymag_q <= dy[16] ? 16'(-dy) : dy[15:0];
      s1_idx_q  <= item_i.index;
      s1_last_q <= item_i.last;

      s2_clip_q <= s1_z_q > 32'(cfg_i.max_depth);
      s2_z_q    <= s1_z_q[Z_W-1:0];
      s2_px_q   <= 40'(s1_xmag_q) * 40'(s1_z_q[Z_W-1:0]);
      s2_py_q   <= 40'(s1_ymag_q) * 40'(s1_z_q[Z_W-1:0]);
      s2_xneg_q <= s1_xneg_q;
      s2_yneg_q <= s1_yneg_q;
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;

      s3_xhi_q  <= 52'(s2_px_q) * 52'(cfg_i.inv_focal_x[23:12]);
      s3_xlo_q  <= 52'(s2_px_q) * 52'(cfg_i.inv_focal_x[11:0]);
      s3_yhi_q  <= 52'(s2_py_q) * 52'(cfg_i.inv_focal_y[23:12]);
      s3_ylo_q  <= 52'(s2_py_q) * 52'(cfg_i.inv_focal_y[11:0]);
      s3_clip_q <= s2_clip_q;
      s3_z_q    <= s2_z_q;
      s3_xneg_q <= s2_xneg_q;
      s3_yneg_q <= s2_yneg_q;
      s3_idx_q  <= s2_idx_q;
      s3_last_q <= s2_last_q;

      point_x_o       <= s3_clip_q ? '0 : lat_finish(s3_xneg_q, s3_xhi_q, s3_xlo_q);
      point_y_o       <= s3_clip_q ? '0 : lat_finish(s3_yneg_q, s3_yhi_q, s3_ylo_q);
      point_z_o       <= s3_clip_q ? '0 : s3_z_q;
      pixel_index_o   <= s3_idx_q;
      clipped_o       <= s3_clip_q;
      last_of_frame_o <= s3_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/depth_to_point_cloud.sv */
// depth to point cloud top level: config registers, intake, queue, pipeline
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------
//   in       | in        | in_valid_i/stall_o | depth_raw_i
//   out      | out       | out_valid_o/stall_i| point_x/y/z_o, pixel_index_o, flags
//   cfg      | in        | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
//
// one request per cycle sustained while the output is not stalled; an accepted request passes
// through the queue, three arithmetic stages, then the output register
// a stalled valid output freezes the whole arithmetic pipeline; the 4-entry queue
// keeps intake going and in_stall_o rises only when it is full
// reset clears counters, queue, pipeline valids and loads default intrinsics
`timescale 1ns / 1ps
`include "assert_macros.svh"
module depth_to_point_cloud import dtpc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [RAW_W-1:0]      depth_raw_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_W-1:0]    point_x_o,
  output logic [COORD_W-1:0]    point_y_o,
  output logic [Z_W-1:0]        point_z_o,
  output logic [IDX_W-1:0]      pixel_index_o,
  output logic                  clipped_o,
  output logic                  last_of_frame_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  q_status_t q_status;
  item_t     push_item, pop_item;
  logic      push, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DEPTH_SCALE:  cfg_d.depth_scale  = cfg_data_i;
        REG_MAX_DEPTH:    cfg_d.max_depth    = cfg_data_i;
        REG_CENTER_X:     cfg_d.center_x     = cfg_data_i[15:0];
        REG_CENTER_Y:     cfg_d.center_y     = cfg_data_i[15:0];
        REG_INV_FOCAL_X:  cfg_d.inv_focal_x  = cfg_data_i;
        REG_INV_FOCAL_Y:  cfg_d.inv_focal_y  = cfg_data_i;
        REG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_data_i[SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height = cfg_data_i[SIZE_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dtpc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .depth_raw_i (depth_raw_i),
    .q_status_i  (q_status),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .item_o      (push_item)
  );

  dtpc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (pop_item),
    .status_o (q_status)
  );

  dtpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_status_i      (q_status),
    .item_i          (pop_item),
    .pop_o           (pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .point_x_o       (point_x_o),
    .point_y_o       (point_y_o),
    .point_z_o       (point_z_o),
    .pixel_index_o   (pixel_index_o),
    .clipped_o       (clipped_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // clipped points are the origin
  `ASSERT_IMPLIES(a_clip_zero, out_valid_o && clipped_o, point_x_o == '0 && point_y_o == '0 && point_z_o == '0, "clipped point not zero")

  // first pixel of a frame carries raster index zero
  `ASSERT_IMPLIES(a_frame_start_idx, push && push_item.column == '0 && push_item.row == '0, push_item.index == '0, "frame start index not zero")

  // a request pushed without a pop leaves the queue occupied
  `ASSERT_ALWAYS(a_queue_hold, !($past(push) && !$past(pop)) || !q_status.empty, "queue lost a request")

endmodule
